// ===== design/dldc_pkg.sv =====
// ----------------------------------------------------------------------------
// dldc_pkg
// Types, constants and helpers shared by the depth low-duration classifier.
// ----------------------------------------------------------------------------
package dldc_pkg;

	localparam int DIM_BITS      = 12;
	localparam int SUM_BITS      = 40;
	localparam int DEPTH_BITS    = 16;
	localparam int TIME_BITS     = 32;
	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_IDX_BITS  = 3;
	localparam int PREV_BITS     = 3;

	// Window count and the threshold limit derived from it.
	localparam int COUNT_BITS = 2 * DIM_BITS;
	localparam int LIMIT_BITS = COUNT_BITS + DEPTH_BITS;
	localparam int CMP_BITS   = (SUM_BITS > LIMIT_BITS) ? SUM_BITS : LIMIT_BITS;

	// Division by three as a multiply by a rounded-up reciprocal. The error
	// stays below one sixth over the whole dimension range, so the floor is exact.
	localparam int THIRD_SHIFT = DIM_BITS + 2;
	localparam int THIRD_RECIP = (2 ** THIRD_SHIFT + 2) / 3;
	localparam int PROD_BITS   = DIM_BITS + THIRD_SHIFT;

	// Frame record queue between the pixel front end and the decision back end.
	localparam int QDEPTH    = 4;
	localparam int QPTR_BITS = $clog2(QDEPTH);
	localparam int QLVL_BITS = $clog2(QDEPTH + 1);

	typedef logic [DIM_BITS-1:0]      dim_t;
	typedef logic [SUM_BITS-1:0]      sum_t;
	typedef logic [DEPTH_BITS-1:0]    depth_t;
	typedef logic [TIME_BITS-1:0]     time_t;
	typedef logic [COUNT_BITS-1:0]    count_t;
	typedef logic [LIMIT_BITS-1:0]    limit_t;
	typedef logic [QLVL_BITS-1:0]     qlvl_t;
	typedef logic [QPTR_BITS-1:0]     qptr_t;
	typedef logic [PREV_BITS-1:0]     prev_t;
	typedef logic [CFG_DATA_BITS-1:0] cfg_data_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_FRAME_WIDTH  = 3'd0,
		CFG_FRAME_HEIGHT = 3'd1,
		CFG_DEPTH_THRESH = 3'd2,
		CFG_SLOW_AFTER   = 3'd3,
		CFG_STOP_AFTER   = 3'd4,
		CFG_STUCK_AFTER  = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ACT_GO    = 2'd0,
		ACT_SLOW  = 2'd1,
		ACT_STOP  = 2'd2,
		ACT_STUCK = 2'd3
	} action_t;

	// Previous action before the first frame: matches no real level.
	localparam prev_t PREV_NONE = 3'd4;

	typedef struct packed {
		dim_t   frame_width;
		dim_t   frame_height;
		depth_t depth_threshold_mm;
		time_t  slow_after_ms;
		time_t  stop_after_ms;
		time_t  stuck_after_ms;
	} cfg_t;

	typedef struct packed {
		sum_t  window_sum;
		time_t now_ms;
	} record_t;

	function automatic dim_t eff_size(dim_t v);
		return (v == '0) ? dim_t'(1) : v;
	endfunction

	function automatic dim_t third_of(dim_t v);
		logic [PROD_BITS-1:0] p;
		p = PROD_BITS'(v) * PROD_BITS'(THIRD_RECIP);
		return p[THIRD_SHIFT +: DIM_BITS];
	endfunction

endpackage

// ===== design/dldc_intf.sv =====
// ----------------------------------------------------------------------------
// dldc_intf
// Valid/ready channels for depth pixels in and frame decisions out.
// ----------------------------------------------------------------------------
interface dldc_in_if;
	import dldc_pkg::*;
	logic   valid;
	logic   ready;
	depth_t depth_mm;
	logic   pixel_invalid;
	time_t  now_ms;

	modport source (output valid, depth_mm, pixel_invalid, now_ms, input ready);
	modport sink (input valid, depth_mm, pixel_invalid, now_ms, output ready);
endinterface

interface dldc_out_if;
	import dldc_pkg::*;
	logic       valid;
	logic       ready;
	time_t      time_below_ms;
	logic [1:0] action_level;
	logic       action_changed;

	modport source (output valid, time_below_ms, action_level, action_changed, input ready);
	modport sink (input valid, time_below_ms, action_level, action_changed, output ready);
endinterface

// ===== design/dldc_queue.sv =====
// ----------------------------------------------------------------------------
// dldc_queue
// Short queue of finished-frame records between front end and back end.
// ----------------------------------------------------------------------------
module dldc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dldc_pkg::record_t push_rec,
	input  logic              pop,
	output dldc_pkg::record_t head,
	output logic              not_empty,
	output dldc_pkg::qlvl_t   level
);
	import dldc_pkg::*;

	record_t mem [QDEPTH];
	qptr_t   wr_ptr_q;
	qptr_t   rd_ptr_q;
	qlvl_t   level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + qptr_t'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + qptr_t'(1);
			end
			if (push && !pop) begin
				level_q <= level_q + qlvl_t'(1);
			end else if (pop && !push) begin
				level_q <= level_q - qlvl_t'(1);
			end
		end
	end

	assign head      = mem[rd_ptr_q];
	assign not_empty = (level_q != '0);
	assign level     = level_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (level_q != qlvl_t'(QDEPTH)))
		else $error("frame queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (level_q != '0))
		else $error("frame queue read while empty");

endmodule

// ===== design/dldc_front.sv =====
// ----------------------------------------------------------------------------
// dldc_front
// Tracks raster position, sums the centre window and queues frame records.
// ----------------------------------------------------------------------------
module dldc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  dldc_pkg::cfg_t    cfg,
	dldc_in_if.sink           in_ch,
	input  dldc_pkg::qlvl_t   q_level,
	output logic              push,
	output dldc_pkg::record_t push_rec
);
	import dldc_pkg::*;

	dim_t                w_eff;
	dim_t                h_eff;
	dim_t                w_third;
	dim_t                h_third;
	logic [DIM_BITS:0]   col_inc;
	logic [DIM_BITS:0]   row_inc;
	logic                row_end;
	logic                frame_end;
	logic                col_in;
	logic                row_in;
	logic                accept;
	logic                pend;
	logic [QLVL_BITS:0]  need;
	logic [SUM_BITS:0]   sum_raw;
	sum_t                sum_sat;

	dim_t   col_q;
	dim_t   row_q;
	sum_t   sum_q;
	logic   valid_s1;
	logic   frame_end_s1;
	depth_t depth_s1;
	time_t  now_s1;

	assign w_eff   = eff_size(cfg.frame_width);
	assign h_eff   = eff_size(cfg.frame_height);
	assign w_third = third_of(w_eff);
	assign h_third = third_of(h_eff);

	assign col_inc   = {1'b0, col_q} + (DIM_BITS+1)'(1);
	assign row_inc   = {1'b0, row_q} + (DIM_BITS+1)'(1);
	assign row_end   = (col_inc >= {1'b0, w_eff});
	assign frame_end = row_end && (row_inc >= {1'b0, h_eff});

	assign col_in = (col_q >= w_third) &&
		({1'b0, col_q} < ({1'b0, w_third} + {1'b0, w_third}));
	assign row_in = (row_q >= h_third) &&
		({1'b0, row_q} < ({1'b0, h_third} + {1'b0, h_third}));

	// A frame end still in stage one is pushed this cycle but is not yet counted in q_level.
	assign pend        = valid_s1 && frame_end_s1;
	assign need        = {1'b0, q_level} + (QLVL_BITS+1)'(pend);
	assign in_ch.ready = (need < (QLVL_BITS+1)'(QDEPTH));
	assign accept      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			valid_s1     <= 1'b0;
			frame_end_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				frame_end_s1 <= frame_end;
				if (!row_end) begin
					col_q <= col_inc[DIM_BITS-1:0];
				end else begin
					col_q <= '0;
					row_q <= frame_end ? '0 : row_inc[DIM_BITS-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			depth_s1 <= (in_ch.pixel_invalid || !col_in || !row_in) ? '0 : in_ch.depth_mm;
			now_s1   <= in_ch.now_ms;
		end
	end

	assign sum_raw = {1'b0, sum_q} + (SUM_BITS+1)'(depth_s1);
	assign sum_sat = sum_raw[SUM_BITS] ? '1 : sum_raw[SUM_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (valid_s1) begin
			sum_q <= frame_end_s1 ? '0 : sum_sat;
		end
	end

	assign push                = pend;
	assign push_rec.window_sum = sum_sat;
	assign push_rec.now_ms     = now_s1;

	a_sum_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && frame_end_s1) |=> (sum_q == '0))
		else $error("window sum not cleared after frame end");

endmodule

// ===== design/dldc_back.sv =====
// ----------------------------------------------------------------------------
// dldc_back
// Per-frame decision: threshold limit, time below, action level and change.
// ----------------------------------------------------------------------------
module dldc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  dldc_pkg::cfg_t    cfg,
	input  dldc_pkg::record_t head,
	input  logic              not_empty,
	output logic              pop,
	dldc_out_if.source        out_ch
);
	import dldc_pkg::*;

	logic    adv;
	logic    clear;
	time_t   diff;
	time_t   below;
	action_t action;
	logic    changed;

	logic    valid_b1;
	record_t rec_b1;
	dim_t    wt_b1;
	dim_t    ht_b1;
	logic    valid_b2;
	record_t rec_b2;
	count_t  count_b2;
	logic    valid_b3;
	record_t rec_b3;
	limit_t  limit_b3;

	time_t   last_above_q;
	prev_t   prev_q;
	logic    out_valid_q;
	time_t   below_q;
	action_t action_q;
	logic    changed_q;

	// The whole decision pipeline moves together whenever the output slot frees.
	assign adv = !out_valid_q || out_ch.ready;
	assign pop = adv && not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_b1    <= 1'b0;
			valid_b2    <= 1'b0;
			valid_b3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_b1    <= pop;
			valid_b2    <= valid_b1;
			valid_b3    <= valid_b2;
			out_valid_q <= valid_b3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rec_b1   <= head;
			wt_b1    <= third_of(eff_size(cfg.frame_width));
			ht_b1    <= third_of(eff_size(cfg.frame_height));
			rec_b2   <= rec_b1;
			count_b2 <= COUNT_BITS'(wt_b1) * COUNT_BITS'(ht_b1);
			rec_b3   <= rec_b2;
			limit_b3 <= LIMIT_BITS'(cfg.depth_threshold_mm) * LIMIT_BITS'(count_b2);
		end
	end

	assign clear = (CMP_BITS'(rec_b3.window_sum) > CMP_BITS'(limit_b3));
	assign diff  = rec_b3.now_ms - last_above_q;
	assign below = clear ? '0 : diff;

	always_comb begin
		priority if (below > cfg.stuck_after_ms) begin
			action = ACT_STUCK;
		end else if (below > cfg.stop_after_ms) begin
			action = ACT_STOP;
		end else if (below > cfg.slow_after_ms) begin
			action = ACT_SLOW;
		end else begin
			action = ACT_GO;
		end
	end

	assign changed = ({1'b0, action} != prev_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_above_q <= '0;
			prev_q       <= PREV_NONE;
		end else if (adv && valid_b3) begin
			if (clear) begin
				last_above_q <= rec_b3.now_ms;
			end
			prev_q <= {1'b0, action};
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_b3) begin
			below_q   <= below;
			action_q  <= action;
			changed_q <= changed;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.time_below_ms  = below_q;
	assign out_ch.action_level   = action_q;
	assign out_ch.action_changed = changed_q;

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && valid_b3) |=> (out_valid_q && (prev_q == {1'b0, action_q})))
		else $error("decision lost between last stage and output register");

endmodule

// ===== design/depth_low_duration_classifier_core.sv =====
// ----------------------------------------------------------------------------
// depth_low_duration_classifier_core
// Centre-window depth classifier: one frame decision per frame of pixels.
// ----------------------------------------------------------------------------
//  Channel  Dir  Beat contents
//  in_ch    in   depth_mm, pixel_invalid, now_ms (one pixel, raster order)
//  out_ch   out  time_below_ms, action_level, action_changed (one per frame)
//  cfg      in   cfg_we, cfg_index, cfg_wdata (write only)
//
// One pixel beat is taken every cycle while the queue has room; the window sum
// adds in the cycle after. A queued record passes through a four-stage
// pipeline (thirds, count multiply, limit multiply, decision) that stalls
// while the output is not taken. Four frame records can wait in the queue; the
// pixel side stalls when it is full, counting a frame end in stage one. Reset
// restores default sizes and thresholds; clears sums, positions, last-above time.
// ----------------------------------------------------------------------------
module depth_low_duration_classifier_core (
	input  logic                              clk,
	input  logic                              arst_n,
	dldc_in_if.sink                           in_ch,
	dldc_out_if.source                        out_ch,
	input  logic                              cfg_we,
	input  logic [dldc_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  dldc_pkg::cfg_data_t               cfg_wdata
);
	import dldc_pkg::*;

	cfg_t    cfg_q;
	logic    push;
	record_t push_rec;
	logic    pop;
	record_t head;
	logic    not_empty;
	qlvl_t   q_level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width        <= dim_t'(640);
			cfg_q.frame_height       <= dim_t'(480);
			cfg_q.depth_threshold_mm <= depth_t'(200);
			cfg_q.slow_after_ms      <= time_t'(500);
			cfg_q.stop_after_ms      <= time_t'(2000);
			cfg_q.stuck_after_ms     <= time_t'(10000);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_FRAME_WIDTH:  cfg_q.frame_width        <= cfg_wdata[DIM_BITS-1:0];
				CFG_FRAME_HEIGHT: cfg_q.frame_height       <= cfg_wdata[DIM_BITS-1:0];
				CFG_DEPTH_THRESH: cfg_q.depth_threshold_mm <= cfg_wdata[DEPTH_BITS-1:0];
				CFG_SLOW_AFTER:   cfg_q.slow_after_ms      <= cfg_wdata[TIME_BITS-1:0];
				CFG_STOP_AFTER:   cfg_q.stop_after_ms      <= cfg_wdata[TIME_BITS-1:0];
				CFG_STUCK_AFTER:  cfg_q.stuck_after_ms     <= cfg_wdata[TIME_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	dldc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_ch    (in_ch),
		.q_level  (q_level),
		.push     (push),
		.push_rec (push_rec)
	);

	dldc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (push_rec),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.level     (q_level)
	);

	dldc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.not_empty (not_empty),
		.pop       (pop),
		.out_ch    (out_ch)
	);

endmodule
